FILE: design/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg
// Constants, codes and the 5-bit check map shared by the frame receiver.
// ----------------------------------------------------------------------------
package rfr_pkg;

	localparam logic [7:0]  PRE_FIRST   = 8'hAA;
	localparam logic [7:0]  PRE_SECOND  = 8'h55;
	localparam logic [4:0]  CRC_INIT    = 5'h1F;
	localparam logic [15:0] TIMEOUT_RST = 16'd100;
	localparam logic [15:0] TICK_MAX    = 16'hFFFF;

	localparam int BODY_W = 64;

	typedef logic [3:0] byte_idx_t;

	localparam byte_idx_t IDX_HUNT  = 4'd0;
	localparam byte_idx_t IDX_PRE2  = 4'd1;
	localparam byte_idx_t IDX_BODY0 = 4'd2;
	localparam byte_idx_t IDX_BODY7 = 4'd9;
	localparam byte_idx_t IDX_CHECK = 4'd10;
	localparam byte_idx_t IDX_TAIL  = 4'd11;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC_ERR = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic {
		MODE_BYTE = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	localparam logic [4:0] CRC_COL [5] = '{5'h05, 5'h0A, 5'h14, 5'h08, 5'h10};

	function automatic logic [4:0] crc_map(input logic [4:0] v);
		logic [4:0] r;
		r = '0;
		for (int k = 0; k < 5; k++) begin
			if (v[k]) begin
				r = r ^ CRC_COL[k];
			end
		end
		return r;
	endfunction

endpackage

FILE: design/rfr_if.sv
// ----------------------------------------------------------------------------
// rfr_if
// Valid/ready channels of the frame receiver: input items and results.
// ----------------------------------------------------------------------------
interface rfr_rx_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface rfr_res_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [rfr_pkg::BODY_W-1:0]  body;
	logic [7:0]                  check_byte;
	logic [7:0]                  tail_byte;

	modport source (output valid, output status, output body, output check_byte,
		output tail_byte, input ready);
	modport sink   (input valid, input status, input body, input check_byte,
		input tail_byte, output ready);
endinterface

FILE: design/result_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// result_frame_receiver_core
// Preamble hunt, frame collection with 5-bit check, and tick timeout.
// ----------------------------------------------------------------------------
// Latency: a result is valid on the cycle after the transfer that causes it.
// Throughput: one byte or tick per cycle; input stalls only while a result
// waits in the output register and the sink is not ready.
// Reset: hunt restarts, running check 0x1F, tick count zero, timeout 100 ticks,
// no result pending.
// ----------------------------------------------------------------------------
module result_frame_receiver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [15:0]  wr_data,
	rfr_rx_if.sink       rx,
	rfr_res_if.source    res
);
	import rfr_pkg::*;

	logic [15:0]        timeout_q;
	byte_idx_t          byte_index_q;
	logic [BODY_W-1:0]  body_q;
	logic [7:0]         check_q;
	logic [4:0]         crc_q;
	logic [15:0]        elapsed_q;

	logic               res_valid_q;
	status_t            res_status_q;
	logic [BODY_W-1:0]  res_body_q;
	logic [7:0]         res_check_q;
	logic [7:0]         res_tail_q;

	byte_idx_t          nxt_index;
	logic [BODY_W-1:0]  nxt_body;
	logic [7:0]         nxt_check;
	logic [4:0]         nxt_crc;
	logic [15:0]        nxt_elapsed;
	logic [15:0]        tick_inc;
	logic               emit;
	status_t            emit_status;
	logic               rx_xfer;

	assign rx.ready = !res_valid_q || res.ready;
	assign rx_xfer  = rx.valid && rx.ready;

	assign tick_inc = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		nxt_index   = byte_index_q;
		nxt_body    = body_q;
		nxt_check   = check_q;
		nxt_crc     = crc_q;
		nxt_elapsed = elapsed_q;
		emit        = 1'b0;
		emit_status = ST_TIMEOUT;
		if (rx.mode == MODE_TICK) begin
			nxt_elapsed = tick_inc;
			emit        = (tick_inc >= timeout_q);
		end else if (elapsed_q >= timeout_q) begin
			emit = 1'b1;
		end else begin
			priority if (byte_index_q == IDX_PRE2) begin
				if (rx.rx_byte == PRE_SECOND) begin
					nxt_index = IDX_BODY0;
				end else begin
					nxt_index = (rx.rx_byte == PRE_FIRST) ? IDX_PRE2 : IDX_HUNT;
				end
			end else if (byte_index_q >= IDX_BODY0 && byte_index_q <= IDX_BODY7) begin
				nxt_body  = {body_q[BODY_W-9:0], rx.rx_byte};
				nxt_crc   = crc_map(crc_q ^ rx.rx_byte[4:0]);
				nxt_index = byte_index_q + 4'd1;
			end else if (byte_index_q == IDX_CHECK) begin
				nxt_check = rx.rx_byte;
				nxt_index = IDX_TAIL;
			end else if (byte_index_q == IDX_TAIL) begin
				emit        = 1'b1;
				emit_status = (crc_q == check_q[4:0]) ? ST_OK : ST_CRC_ERR;
			end else begin
				nxt_index = (rx.rx_byte == PRE_FIRST) ? IDX_PRE2 : IDX_HUNT;
			end
		end
		if (emit) begin
			nxt_index   = IDX_HUNT;
			nxt_body    = '0;
			nxt_check   = '0;
			nxt_crc     = CRC_INIT;
			nxt_elapsed = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RST;
			byte_index_q <= IDX_HUNT;
			body_q       <= '0;
			check_q      <= '0;
			crc_q        <= CRC_INIT;
			elapsed_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				timeout_q <= wr_data;
			end
			if (rx_xfer) begin
				byte_index_q <= nxt_index;
				body_q       <= nxt_body;
				check_q      <= nxt_check;
				crc_q        <= nxt_crc;
				elapsed_q    <= nxt_elapsed;
			end
			if (rx.ready) begin
				res_valid_q <= rx_xfer && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_xfer && emit) begin
			res_status_q <= emit_status;
			if (emit_status == ST_TIMEOUT) begin
				res_body_q  <= '0;
				res_check_q <= '0;
				res_tail_q  <= '0;
			end else begin
				res_body_q  <= body_q;
				res_check_q <= check_q;
				res_tail_q  <= rx.rx_byte;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.body       = res_body_q;
	assign res.check_byte = res_check_q;
	assign res.tail_byte  = res_tail_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_xfer && res_valid_q && !res.ready))
		else $error("input transfer while result stalled");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_TAIL)
		else $error("byte index out of range");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_xfer && emit) |=> (byte_index_q == IDX_HUNT && elapsed_q == '0
		&& crc_q == CRC_INIT))
		else $error("attempt not restarted after result");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == ST_TIMEOUT) |-> (res_body_q == '0
		&& res_check_q == '0 && res_tail_q == '0))
		else $error("timeout result carries frame data");
`endif

endmodule
